>>> design/lesm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lesm_pkg;

  // Zone count and brightness limits
  localparam int unsigned ZONES       = 8;
  localparam int unsigned ZONE_W      = 7;
  localparam int unsigned TOTAL_W     = 10;
  localparam logic [ZONE_W-1:0]  FULL_PCT    = 7'd100;
  localparam logic [TOTAL_W-1:0] BASE_PER_MS = TOTAL_W'(ZONES * 100);

  // Savings scaling in hundredths of a percent
  localparam int unsigned SAV_W = 14;
  localparam logic [SAV_W-1:0] SAV_SCALE = 14'd10000;

  // Long division over the widest dividend (64 x 16 bit product)
  localparam int unsigned DIVD_W    = 80;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Energy scaling: mWh = accum * deciwatts / 3600000, where
  // 3600000 = 128 * 28125. Divide by 28125 one 16-bit digit at a time;
  // each digit is estimated as (x * RECIP) >> 46, exact for x below 2^31.
  localparam int unsigned MWH_SHIFT    = 7;
  localparam int unsigned MWH_REM_W    = 15;
  localparam int unsigned MWH_DIG_W    = 16;
  localparam int unsigned MWH_X_W      = MWH_REM_W + MWH_DIG_W;
  localparam int unsigned MWH_RECIP_SH = 46;
  localparam logic [MWH_REM_W-1:0] MWH_ODD   = 15'd28125;
  localparam logic [31:0]          MWH_RECIP = 32'd2501999793;
  // Each digit takes an estimate step, then a remainder step
  localparam int unsigned MWH_STEPS = 2 * (DIVD_W / MWH_DIG_W);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_ACCUM   = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [63:0]       time_ms;
    logic [ZONE_W-1:0] zone_brightness_0;
    logic [ZONE_W-1:0] zone_brightness_1;
    logic [ZONE_W-1:0] zone_brightness_2;
    logic [ZONE_W-1:0] zone_brightness_3;
    logic [ZONE_W-1:0] zone_brightness_4;
    logic [ZONE_W-1:0] zone_brightness_5;
    logic [ZONE_W-1:0] zone_brightness_6;
    logic [ZONE_W-1:0] zone_brightness_7;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       update_kind;
    logic [SAV_W-1:0] savings_hundredths;
    logic [62:0]      actual_energy_mwh;
    logic [62:0]      baseline_energy_mwh;
  } out_word_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic mult;
    logic accum;
    logic prod;
    logic nprod;
    logic nsum;
    logic div_step;
    logic mwh_mul;
    logic mwh_sub;
    logic out_load;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/lesm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lesm_in_if;
  import lesm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lesm_out_if;
  import lesm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lesm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/lesm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lesm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lesm_pkg::cmd_t cmd
);
  import lesm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MULT  = 8'b0000_0010,
    S_ACCUM = 8'b0000_0100,
    S_PROD  = 8'b0000_1000,
    S_NPROD = 8'b0001_0000,
    S_NSUM  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;
  logic             mwh_busy;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Energy digits run during the first divider steps
  assign mwh_busy  = (state_r == S_DIV) && (cnt_r < CNT_W'(MWH_STEPS));

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.mult     = (state_r == S_MULT);
    cmd.accum    = (state_r == S_ACCUM);
    cmd.prod     = (state_r == S_PROD);
    cmd.nprod    = (state_r == S_NPROD);
    cmd.nsum     = (state_r == S_NSUM);
    cmd.div_step = (state_r == S_DIV);
    cmd.mwh_mul  = mwh_busy && !cnt_r[0];
    cmd.mwh_sub  = mwh_busy && cnt_r[0];
    cmd.out_load = (state_r == S_OUT) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MULT;
      S_MULT:  state_nxt = S_ACCUM;
      S_ACCUM: state_nxt = S_PROD;
      S_PROD:  state_nxt = S_NPROD;
      S_NPROD: state_nxt = S_NSUM;
      S_NSUM: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lesm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lesm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lesm_pkg::cmd_t      cmd,
  input  lesm_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output lesm_pkg::out_word_t out_word
);
  import lesm_pkg::*;

  // Meter state
  logic [63:0] last_time_r, last_time_nxt;
  logic [63:0] actual_r, actual_nxt;
  logic [63:0] baseline_r, baseline_nxt;
  logic [15:0] rated_r, rated_nxt;

  // Per-word working registers
  kind_t              kind_r, kind_nxt;
  logic [63:0]        elapsed_r, elapsed_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [41:0]        pa_lo_r, pa_hi_r, pb_lo_r, pb_hi_r;
  logic [47:0]        ma_lo_r, ma_hi_r, mb_lo_r, mb_hi_r;
  logic [45:0]        n_lo_r, n_hi_r;
  logic [63:0]        diff_r;
  logic               sav_zero_r;
  logic [DIVD_W-1:0]  qa_r, qa_nxt, qb_r, qb_nxt, qs_r, qs_nxt;
  logic [MWH_REM_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [MWH_DIG_W-1:0] qda_r, qdb_r;
  logic [63:0]        rs_r, rs_nxt;
  out_word_t          out_r;

  logic [ZONE_W-1:0]  zone [8];
  logic [TOTAL_W-1:0] zone_sum;

  assign zone[0] = in_word.zone_brightness_0;
  assign zone[1] = in_word.zone_brightness_1;
  assign zone[2] = in_word.zone_brightness_2;
  assign zone[3] = in_word.zone_brightness_3;
  assign zone[4] = in_word.zone_brightness_4;
  assign zone[5] = in_word.zone_brightness_5;
  assign zone[6] = in_word.zone_brightness_6;
  assign zone[7] = in_word.zone_brightness_7;

  // Clamp each zone to full brightness and add them up
  always_comb begin
    zone_sum = '0;
    for (int z = 0; z < ZONES; z++) begin
      zone_sum = zone_sum + TOTAL_W'((zone[z] > FULL_PCT) ? FULL_PCT : zone[z]);
    end
  end

  // Classify the word and capture elapsed time
  always_comb begin
    last_time_nxt = last_time_r;
    kind_nxt      = kind_r;
    elapsed_nxt   = elapsed_r;
    total_nxt     = total_r;
    if (cmd.load) begin
      total_nxt   = zone_sum;
      elapsed_nxt = in_word.time_ms - last_time_r;
      if (last_time_r == '0) begin
        kind_nxt      = KIND_START;
        last_time_nxt = in_word.time_ms;
      end else if (in_word.time_ms <= last_time_r) begin
        kind_nxt = KIND_IGNORED;
      end else begin
        kind_nxt      = KIND_ACCUM;
        last_time_nxt = in_word.time_ms;
      end
    end
  end

  // Update accumulators, wrapping modulo 2^64
  always_comb begin
    actual_nxt   = actual_r;
    baseline_nxt = baseline_r;
    if (cmd.accum && (kind_r == KIND_ACCUM)) begin
      actual_nxt   = actual_r + 64'(pa_lo_r) + {pa_hi_r[31:0], 32'd0};
      baseline_nxt = baseline_r + 64'(pb_lo_r) + {pb_hi_r[31:0], 32'd0};
    end
  end

  assign rated_nxt = cfg_we ? cfg_data : rated_r;

  // Savings: long division by the baseline, one quotient bit a step
  logic [64:0]        ts;
  logic               ges;

  assign ts  = {rs_r, qs_r[DIVD_W-1]};
  assign ges = ts >= {1'b0, baseline_r};

  // Energy: full products, then digit division by 28125 after dropping 2^7
  logic [DIVD_W-1:0]  pa, pb;
  logic [MWH_X_W-1:0] xa, xb;
  logic [62:0]        ea, eb;

  assign pa = DIVD_W'(ma_lo_r) + {ma_hi_r, 32'd0};
  assign pb = DIVD_W'(mb_lo_r) + {mb_hi_r, 32'd0};
  assign xa = {ra_r, qa_r[DIVD_W-1 -: MWH_DIG_W]};
  assign xb = {rb_r, qb_r[DIVD_W-1 -: MWH_DIG_W]};
  assign ea = 63'(xa) * 63'(MWH_RECIP);
  assign eb = 63'(xb) * 63'(MWH_RECIP);

  always_comb begin
    qa_nxt = qa_r;
    qb_nxt = qb_r;
    qs_nxt = qs_r;
    ra_nxt = ra_r;
    rb_nxt = rb_r;
    rs_nxt = rs_r;
    if (cmd.nprod) begin
      qa_nxt = pa >> MWH_SHIFT;
      qb_nxt = pb >> MWH_SHIFT;
      ra_nxt = '0;
      rb_nxt = '0;
    end else if (cmd.mwh_sub) begin
      // Shift in the estimated digit and keep what is left over
      qa_nxt = {qa_r[DIVD_W-MWH_DIG_W-1:0], qda_r};
      qb_nxt = {qb_r[DIVD_W-MWH_DIG_W-1:0], qdb_r};
      ra_nxt = MWH_REM_W'(xa - MWH_X_W'(qda_r) * MWH_X_W'(MWH_ODD));
      rb_nxt = MWH_REM_W'(xb - MWH_X_W'(qdb_r) * MWH_X_W'(MWH_ODD));
    end
    if (cmd.nsum) begin
      qs_nxt = DIVD_W'(n_lo_r) + DIVD_W'({n_hi_r, 32'd0});
      rs_nxt = '0;
    end else if (cmd.div_step) begin
      qs_nxt = {qs_r[DIVD_W-2:0], ges};
      rs_nxt = ges ? 64'(ts - {1'b0, baseline_r}) : ts[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      actual_r    <= '0;
      baseline_r  <= '0;
      rated_r     <= '0;
    end else begin
      last_time_r <= last_time_nxt;
      actual_r    <= actual_nxt;
      baseline_r  <= baseline_nxt;
      rated_r     <= rated_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    elapsed_r <= elapsed_nxt;
    total_r   <= total_nxt;
    qa_r      <= qa_nxt;
    qb_r      <= qb_nxt;
    qs_r      <= qs_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    rs_r      <= rs_nxt;
    if (cmd.mult) begin
      pa_lo_r <= 42'(elapsed_r[31:0]) * 42'(total_r);
      pa_hi_r <= 42'(elapsed_r[63:32]) * 42'(total_r);
      pb_lo_r <= 42'(elapsed_r[31:0]) * 42'(BASE_PER_MS);
      pb_hi_r <= 42'(elapsed_r[63:32]) * 42'(BASE_PER_MS);
    end
    if (cmd.prod) begin
      ma_lo_r    <= 48'(actual_r[31:0]) * 48'(rated_r);
      ma_hi_r    <= 48'(actual_r[63:32]) * 48'(rated_r);
      mb_lo_r    <= 48'(baseline_r[31:0]) * 48'(rated_r);
      mb_hi_r    <= 48'(baseline_r[63:32]) * 48'(rated_r);
      diff_r     <= baseline_r - actual_r;
      sav_zero_r <= (baseline_r == '0) || (actual_r >= baseline_r);
    end
    if (cmd.nprod) begin
      n_lo_r <= 46'(diff_r[31:0]) * 46'(SAV_SCALE);
      n_hi_r <= 46'(diff_r[63:32]) * 46'(SAV_SCALE);
    end
    if (cmd.mwh_mul) begin
      qda_r <= MWH_DIG_W'(ea >> MWH_RECIP_SH);
      qdb_r <= MWH_DIG_W'(eb >> MWH_RECIP_SH);
    end
    if (cmd.out_load) begin
      out_r.update_kind         <= kind_r;
      out_r.savings_hundredths  <= sav_zero_r ? '0 : qs_r[SAV_W-1:0];
      out_r.actual_energy_mwh   <= qa_r[62:0];
      out_r.baseline_energy_mwh <= qb_r[62:0];
    end
  end

  assign out_word = out_r;

endmodule
`default_nettype wire

>>> design/lighting_energy_savings_meter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Lighting energy savings meter. Each input word carries a millisecond
// timestamp and the brightness of eight zones (values above 100 count as
// 100); each word yields exactly one result word. The first word after reset
// with a nonzero time starts the meter; a word whose time does not advance
// changes nothing; otherwise the zone sum times elapsed ms is added to the
// actual accumulator and 800 times elapsed ms to the baseline, both wrapping
// at 64 bits. Results report the update kind, the savings in hundredths of a
// percent (zero when the baseline is zero or not above actual), and both
// energies in mWh scaled by the rated power register, truncated. After the
// accepting edge a word passes through the multiply, accumulate, product,
// scaled-product and sum states of split 32-bit multiplies and sums, 80
// steps of the bit-serial long divider for the savings ratio, and a load
// of the result register that waits for the output to be free; the two
// divisions by 3600000 run beside the first ten divider steps as 16-bit
// digits estimated by a reciprocal multiply. A new word is taken only once
// the last one is through; it is accepted as soon as the result is parked,
// even before the sink takes it. Write the rated power only while the meter
// is idle; the configuration port is always ready.
module lighting_energy_savings_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  lesm_in_if.sink     in_ch,
  lesm_out_if.source  out_ch,
  lesm_cfg_if.sink    cfg_ch
);
  import lesm_pkg::*;

  cmd_t cmd;

  // Accept a register write on every valid cycle
  assign cfg_ch.ready = 1'b1;

  // Sequence the accept, multiply, divide and output steps
  lesm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Hold meter state, products, dividers and the result register
  lesm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_ch.data),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .out_word (out_ch.data)
  );

endmodule
`default_nettype wire
